[src/mexp_pkg.sv]
// ----------------------------------------------------------------------------
// Modular exponentiation package
// Shared widths, register indexes and the bundles that pass between the
// sequencer and the modular multiplier.
// ----------------------------------------------------------------------------
package mexp_pkg;

    // Operand widths
    localparam int MOD_BITS  = 31;
    localparam int EXP_BITS  = 32;
    localparam int CNT_W     = $clog2(MOD_BITS);
    localparam int EXP_IDX_W = $clog2(EXP_BITS);

    // Key modulus after reset: product of the two primes
    localparam int unsigned P_FACTOR = 101;
    localparam int unsigned Q_FACTOR = 179;
    localparam logic [MOD_BITS-1:0] MOD_RESET = MOD_BITS'(P_FACTOR * Q_FACTOR);
    localparam logic [EXP_BITS-1:0] EXP_RESET = EXP_BITS'(1);

    // Configuration register indexes
    localparam logic REG_EXPONENT = 1'b0;
    localparam logic REG_MODULUS  = 1'b1;

    // Request into the modular multiplier
    typedef struct packed {
        logic                start;
        logic [MOD_BITS-1:0] a;
        logic [MOD_BITS-1:0] b;
        logic [MOD_BITS-1:0] m;
    } mexp_mul_req_t;

    // Response from the modular multiplier
    typedef struct packed {
        logic                done;
        logic [MOD_BITS-1:0] result;
    } mexp_mul_rsp_t;

endpackage

[src/mexp_mulmod.sv]
// ----------------------------------------------------------------------------
// Radix-2 interleaved modular multiplier
// Computes a * b mod m, one bit of b per cycle from the top down. Requires
// a < m; b may take any value of the operand width.
// ----------------------------------------------------------------------------
module mexp_mulmod (
    input  logic                   clk,
    input  logic                   rst_n,
    input  mexp_pkg::mexp_mul_req_t req,
    output mexp_pkg::mexp_mul_rsp_t rsp
);

    localparam int W = mexp_pkg::MOD_BITS + 2;

    logic                          busy_reg;
    logic                          done_reg;
    logic [mexp_pkg::CNT_W-1:0]    cnt_reg;
    logic [mexp_pkg::MOD_BITS-1:0] r_reg, r_next;
    logic [mexp_pkg::MOD_BITS-1:0] a_reg;
    logic [mexp_pkg::MOD_BITS-1:0] b_reg;

    logic [W-1:0] sum;
    logic [W:0]   diff1;
    logic [W:0]   diff2;

    // Double, add the operand if the current bit is set, then fold back below m
    always_comb
    begin
        sum   = {1'b0, r_reg, 1'b0}
              + {2'b00, (b_reg[mexp_pkg::MOD_BITS-1] ? a_reg : '0)};
        diff1 = {1'b0, sum} - {3'b000, req.m};
        diff2 = {1'b0, sum} - {2'b00, req.m, 1'b0};
        if (!diff2[W])
        begin
            r_next = diff2[mexp_pkg::MOD_BITS-1:0];
        end
        else if (!diff1[W])
        begin
            r_next = diff1[mexp_pkg::MOD_BITS-1:0];
        end
        else
        begin
            r_next = sum[mexp_pkg::MOD_BITS-1:0];
        end
    end

    // Control: start loads operands, last bit raises done for one cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (req.start && !busy_reg)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= mexp_pkg::CNT_W'(mexp_pkg::MOD_BITS - 1);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (req.start && !busy_reg)
        begin
            r_reg <= '0;
            a_reg <= req.a;
            b_reg <= req.b;
        end
        else if (busy_reg)
        begin
            r_reg <= r_next;
            b_reg <= {b_reg[mexp_pkg::MOD_BITS-2:0], 1'b0};
        end
    end

    assign rsp.done   = done_reg;
    assign rsp.result = r_reg;

endmodule

[src/modular_exponentiation.sv]
// ----------------------------------------------------------------------------
// Modular exponentiation
// Raises each input word to the configured exponent modulo the configured
// modulus by right-to-left binary square-and-multiply.
// ----------------------------------------------------------------------------
// One item is in flight at a time. All arithmetic runs on a single radix-2
// interleaved modular multiplier that steps through the 31 bits of its
// second operand. An item costs one product to reduce the base, then for
// each of the 32 exponent bits a dispatch state, one squaring and, where the
// bit is set, one more product. A modulus below 2 skips the work and yields
// 0. A finished result sits in the output register while the next item is
// taken.
// ----------------------------------------------------------------------------
module modular_exponentiation (
    input  logic        clk,
    input  logic        rst_n,
    // Configuration writes
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [30:0] value, [31] zero fill
    input  logic        s_tlast,   // last_in
    // Output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [30:0] residue, [31] zero fill
    output logic        m_tlast    // last_out
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_REDUCE = 3'd1;
    localparam logic [2:0] ST_BIT    = 3'd2;
    localparam logic [2:0] ST_MULT   = 3'd3;
    localparam logic [2:0] ST_SQR    = 3'd4;
    localparam logic [2:0] ST_OUT    = 3'd5;

    logic [2:0]                      state_reg, state_next;
    logic [mexp_pkg::EXP_BITS-1:0]   exponent_reg;
    logic [mexp_pkg::MOD_BITS-1:0]   modulus_reg;
    logic [mexp_pkg::EXP_BITS-1:0]   ex_reg;
    logic [mexp_pkg::MOD_BITS-1:0]   m_reg;
    logic [mexp_pkg::MOD_BITS-1:0]   base_reg;
    logic [mexp_pkg::MOD_BITS-1:0]   acc_reg;
    logic [mexp_pkg::EXP_IDX_W-1:0]  idx_reg;
    logic                            last_reg;
    logic                            out_valid_reg;
    logic [mexp_pkg::MOD_BITS-1:0]   out_data_reg;
    logic                            out_last_reg;

    mexp_pkg::mexp_mul_req_t mul_req;
    mexp_pkg::mexp_mul_rsp_t mul_rsp;

    logic in_xfer;
    logic out_free;
    logic last_bit;

    assign s_tready = (state_reg == ST_IDLE);
    assign in_xfer  = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign last_bit = (idx_reg == mexp_pkg::EXP_IDX_W'(mexp_pkg::EXP_BITS - 1));

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exponent_reg <= mexp_pkg::EXP_RESET;
            modulus_reg  <= mexp_pkg::MOD_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                mexp_pkg::REG_EXPONENT: exponent_reg <= cfg_data;
                mexp_pkg::REG_MODULUS:  modulus_reg  <= cfg_data[mexp_pkg::MOD_BITS-1:0];
                default:                exponent_reg <= exponent_reg;
            endcase
        end
    end

    // Issue requests to the shared multiplier
    always_comb
    begin
        mul_req.start = 1'b0;
        mul_req.a     = base_reg;
        mul_req.b     = base_reg;
        mul_req.m     = m_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                // Reduce the base: 1 * value mod m
                mul_req.start = in_xfer && (modulus_reg > mexp_pkg::MOD_BITS'(1));
                mul_req.a     = mexp_pkg::MOD_BITS'(1);
                mul_req.b     = s_tdata[mexp_pkg::MOD_BITS-1:0];
                mul_req.m     = modulus_reg;
            end
            ST_BIT:
            begin
                mul_req.start = 1'b1;
                mul_req.a     = ex_reg[idx_reg] ? acc_reg : base_reg;
            end
            ST_MULT:
            begin
                mul_req.start = mul_rsp.done;
            end
            default:
            begin
                mul_req.start = 1'b0;
            end
        endcase
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = (modulus_reg > mexp_pkg::MOD_BITS'(1)) ? ST_REDUCE : ST_OUT;
                end
            end
            ST_REDUCE: if (mul_rsp.done) state_next = ST_BIT;
            ST_BIT:    state_next = ex_reg[idx_reg] ? ST_MULT : ST_SQR;
            ST_MULT:   if (mul_rsp.done) state_next = ST_SQR;
            ST_SQR:
            begin
                if (mul_rsp.done)
                begin
                    state_next = last_bit ? ST_OUT : ST_BIT;
                end
            end
            ST_OUT:    if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_OUT && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Item datapath: latch keys, hold base and accumulator, step the bit index
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            ex_reg   <= exponent_reg;
            m_reg    <= modulus_reg;
            last_reg <= s_tlast;
            acc_reg  <= (modulus_reg > mexp_pkg::MOD_BITS'(1)) ? mexp_pkg::MOD_BITS'(1) : '0;
            idx_reg  <= '0;
        end
        if (state_reg == ST_REDUCE && mul_rsp.done)
        begin
            base_reg <= mul_rsp.result;
        end
        if (state_reg == ST_MULT && mul_rsp.done)
        begin
            acc_reg <= mul_rsp.result;
        end
        if (state_reg == ST_SQR && mul_rsp.done)
        begin
            base_reg <= mul_rsp.result;
            idx_reg  <= idx_reg + 1'b1;
        end
        if (state_reg == ST_OUT && out_free)
        begin
            out_data_reg <= acc_reg;
            out_last_reg <= last_reg;
        end
    end

    mexp_mulmod u_mulmod (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .rsp   (mul_rsp)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_data_reg};
    assign m_tlast  = out_last_reg;

endmodule

[src/mexp_checker.sv]
// ----------------------------------------------------------------------------
// Modular exponentiation port checker
// Watches the top-level streams for stalls and single-item sequencing.
// ----------------------------------------------------------------------------
module mexp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tlast
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

    // Drop ready once an item is taken
    a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while busy");

    // No result appears in the cycle after a transfer in
    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !$rose(m_tvalid))
        else $error("result too early");

endmodule

bind modular_exponentiation mexp_checker u_mexp_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

[tb/sv/tb_modular_exponentiation.sv]
// ----------------------------------------------------------------------------
// Modular exponentiation testbench
// Streams base words through the exponentiation unit under many exponent and
// modulus settings. A directed table covers the extremes and the special cases,
// then random phases follow. Results are checked against a typed residue or a
// square-and-multiply predictor. Sender and receiver both pause at random.
// ----------------------------------------------------------------------------
module tb_modular_exponentiation;

    // Kinds of row in the directed table
    typedef enum logic [1:0] {
        ROW_ITEM,
        ROW_EXP,
        ROW_MOD
    } row_kind_t;

    // One directed row: an item, or a write of one key register
    typedef struct packed {
        row_kind_t   kind;
        logic [31:0] data;      // base for an item, register value for a write
        logic        last;
        logic        known;     // residue typed in below
        logic [30:0] residue;
    } stim_row_t;

    // One residue still owed by the block
    typedef struct packed {
        logic [30:0] residue;
        logic        last;
    } residue_exp_t;

    localparam int N_DIRECTED   = 32;
    localparam int RANDOM_ITEMS = 225;
    localparam int DRAIN_CYCLES = 2300;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_index;
    logic [31:0] cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // [30:0] value, [31] zero fill
    logic        s_tlast;   // last_in
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;   // [30:0] residue, [31] zero fill
    logic        m_tlast;   // last_out

    // Key registers as the block should hold them
    logic [31:0] key_exponent;
    logic [30:0] key_modulus;

    residue_exp_t pending_residues [$];
    int           mismatch_count;
    int           burst_left;
    int           items_sent;

    // Receiver stall pattern
    int stall_left = 0;
    int stall_mode = 0;
    int mode_left  = 0;

    stim_row_t directed_rows [N_DIRECTED] = '{
        // reset keys: exponent 1, modulus 18079
        '{ROW_ITEM, 32'd0,          1'b0, 1'b1, 31'd0},
        '{ROW_ITEM, 32'd5,          1'b0, 1'b1, 31'd5},
        '{ROW_ITEM, 32'd18079,      1'b0, 1'b1, 31'd0},
        '{ROW_ITEM, 32'd18080,      1'b0, 1'b1, 31'd1},
        '{ROW_ITEM, 32'h7FFF_FFFF,  1'b1, 1'b1, 31'd5790},
        // zero exponent yields one, zero base included
        '{ROW_EXP,  32'd0,          1'b0, 1'b0, 31'd0},
        '{ROW_ITEM, 32'd12345,      1'b0, 1'b1, 31'd1},
        '{ROW_ITEM, 32'd0,          1'b1, 1'b1, 31'd1},
        // smallest legal modulus
        '{ROW_MOD,  32'd2,          1'b0, 1'b0, 31'd0},
        '{ROW_ITEM, 32'd7,          1'b0, 1'b1, 31'd1},
        '{ROW_EXP,  32'hFFFF_FFFF,  1'b0, 1'b0, 31'd0},
        '{ROW_ITEM, 32'd7,          1'b0, 1'b1, 31'd1},
        '{ROW_ITEM, 32'd6,          1'b1, 1'b1, 31'd0},
        // largest modulus: minus one to an odd power stays minus one
        '{ROW_MOD,  32'h7FFF_FFFF,  1'b0, 1'b0, 31'd0},
        '{ROW_ITEM, 32'h7FFF_FFFE,  1'b0, 1'b1, 31'h7FFF_FFFE},
        '{ROW_ITEM, 32'h7FFF_FFFF,  1'b0, 1'b1, 31'd0},
        '{ROW_ITEM, 32'd2,          1'b1, 1'b0, 31'd0},
        // modulus below two gives zero; the top data bit is dropped
        '{ROW_MOD,  32'd1,          1'b0, 1'b0, 31'd0},
        '{ROW_ITEM, 32'd99,         1'b0, 1'b1, 31'd0},
        '{ROW_MOD,  32'h8000_0000,  1'b0, 1'b0, 31'd0},
        '{ROW_ITEM, 32'd99,         1'b0, 1'b1, 31'd0},
        '{ROW_ITEM, 32'd0,          1'b1, 1'b1, 31'd0},
        // small key pair on the reset modulus
        '{ROW_MOD,  32'd18079,      1'b0, 1'b0, 31'd0},
        '{ROW_EXP,  32'd7,          1'b0, 1'b0, 31'd0},
        '{ROW_ITEM, 32'd65,         1'b0, 1'b0, 31'd0},
        '{ROW_ITEM, 32'h2AAA_AAAA,  1'b1, 1'b0, 31'd0},
        '{ROW_EXP,  32'd2543,       1'b0, 1'b0, 31'd0},
        '{ROW_ITEM, 32'd65,         1'b0, 1'b0, 31'd0},
        // top exponent bit alone, then the common public exponent
        '{ROW_EXP,  32'h8000_0000,  1'b0, 1'b0, 31'd0},
        '{ROW_ITEM, 32'd3,          1'b0, 1'b0, 31'd0},
        '{ROW_EXP,  32'd65537,      1'b0, 1'b0, 31'd0},
        '{ROW_ITEM, 32'h4000_0000,  1'b1, 1'b0, 31'd0}
    };

    modular_exponentiation dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always #5 clk = ~clk;

    // Right-to-left square-and-multiply on 64-bit products
    function automatic logic [30:0] modexp_residue(input logic [30:0] base_word,
                                                   input logic [31:0] ex,
                                                   input logic [30:0] m);
        longint unsigned acc;
        longint unsigned sq;
        longint unsigned mm;
        int              i;
        acc = 1;
        mm  = m;
        if (mm < 2)
            return '0;
        sq = base_word % mm;
        for (i = 0; i < mexp_pkg::EXP_BITS; i++)
        begin
            if (ex[i])
                acc = (acc * sq) % mm;
            sq = (sq * sq) % mm;
        end
        return acc[30:0];
    endfunction

    // Offer one base word; hold it until the transfer, then log the residue
    task automatic send_word(input logic [30:0] base_word, input logic last,
                             input logic known, input logic [30:0] known_residue);
        int           gap;
        residue_exp_t owed;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(200, 2500)
                                              : $urandom_range(0, 12);
            if (gap > 0)
            begin
                s_tvalid = 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 10);
        end
        s_tvalid = 1'b1;
        s_tdata  = {1'b0, base_word};
        s_tlast  = last;
        do
            @(posedge clk);
        while (!s_tready);
        owed.residue = known ? known_residue
                             : modexp_residue(base_word, key_exponent, key_modulus);
        owed.last    = last;
        pending_residues.push_back(owed);
        burst_left--;
        items_sent++;
        @(negedge clk);
    endtask

    // Drop valid and wait until every owed residue has come back
    task automatic drain_results();
        s_tvalid = 1'b0;
        while (pending_residues.size() != 0)
            @(negedge clk);
    endtask

    // Write one key register and track it in the predictor
    task automatic write_key(input logic idx, input logic [31:0] data);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        if (idx == mexp_pkg::REG_EXPONENT)
            key_exponent = data;
        else
            key_modulus = data[30:0];
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // Receiver: change stall mode now and then, insert short and long stalls
    always @(negedge clk)
    begin
        if (mode_left == 0)
        begin
            stall_mode = $urandom_range(0, 2);
            mode_left  = $urandom_range(500, 6000);
        end
        else
            mode_left--;
        if (stall_left != 0)
        begin
            stall_left--;
            m_tready = 1'b0;
        end
        else
        begin
            case (stall_mode)
                0: m_tready = 1'b1;
                1: m_tready = ($urandom_range(0, 2) != 0);
                default:
                begin
                    if ($urandom_range(0, 399) == 0)
                    begin
                        stall_left = $urandom_range(1, 2500);
                        m_tready   = 1'b0;
                    end
                    else
                        m_tready = 1'b1;
                end
            endcase
        end
    end

    // Check each result transfer against the oldest owed residue
    always @(posedge clk)
    begin
        residue_exp_t owed;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_residues.size() == 0)
            begin
                $error("unexpected result: residue %0d, last %0b", m_tdata[30:0], m_tlast);
                mismatch_count++;
            end
            else
            begin
                owed = pending_residues.pop_front();
                if (m_tdata[30:0] !== owed.residue)
                begin
                    $error("residue: expected %0d, got %0d", owed.residue, m_tdata[30:0]);
                    mismatch_count++;
                end
                if (m_tlast !== owed.last)
                begin
                    $error("last_out: expected %0b, got %0b", owed.last, m_tlast);
                    mismatch_count++;
                end
            end
        end
    end

    // Stimulus
    initial
    begin
        int          r;
        int          phase_len;
        logic [31:0] ex_pick;
        logic [30:0] mod_pick;
        logic [30:0] base_pick;

        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = mexp_pkg::REG_EXPONENT;
        cfg_data       = '0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tlast        = 1'b0;
        key_exponent   = mexp_pkg::EXP_RESET;
        key_modulus    = mexp_pkg::MOD_RESET;
        mismatch_count = 0;
        burst_left     = 0;
        items_sent     = 0;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed table
        foreach (directed_rows[k])
        begin
            case (directed_rows[k].kind)
                ROW_EXP:
                begin
                    drain_results();
                    write_key(mexp_pkg::REG_EXPONENT, directed_rows[k].data);
                end
                ROW_MOD:
                begin
                    drain_results();
                    write_key(mexp_pkg::REG_MODULUS, directed_rows[k].data);
                end
                default:
                    send_word(directed_rows[k].data[30:0], directed_rows[k].last,
                              directed_rows[k].known, directed_rows[k].residue);
            endcase
        end

        // Random phases, each under a fresh pair of keys
        while (items_sent < N_DIRECTED + RANDOM_ITEMS)
        begin
            drain_results();

            r = $urandom_range(0, 9);
            case (r)
                0: ex_pick = 32'd0;
                1: ex_pick = 32'd1;
                2: ex_pick = 32'hFFFF_FFFF;
                3: ex_pick = $urandom_range(2, 16);
                4: ex_pick = 32'd65537;
                default: ex_pick = $urandom;
            endcase

            r = $urandom_range(0, 9);
            case (r)
                0: mod_pick = 31'd18079;
                1: mod_pick = 31'($urandom_range(2, 255));
                2: mod_pick = 31'h7FFF_FFFF;
                3: mod_pick = ($urandom_range(0, 3) == 0) ? 31'($urandom_range(0, 1)) : 31'd2;
                default:
                begin
                    mod_pick = 31'($urandom);
                    if (mod_pick < 2)
                        mod_pick = 31'd3;
                end
            endcase

            if ($urandom_range(0, 1) == 0)
            begin
                write_key(mexp_pkg::REG_EXPONENT, ex_pick);
                write_key(mexp_pkg::REG_MODULUS, {1'($urandom_range(0, 1)), mod_pick});
            end
            else
            begin
                write_key(mexp_pkg::REG_MODULUS, {1'($urandom_range(0, 1)), mod_pick});
                write_key(mexp_pkg::REG_EXPONENT, ex_pick);
            end

            phase_len = $urandom_range(5, 25);
            repeat (phase_len)
            begin
                r = $urandom_range(0, 11);
                case (r)
                    0, 1, 2, 3: base_pick = 31'($urandom_range(0, 255));
                    4:          base_pick = '0;
                    5:          base_pick = 31'h7FFF_FFFF;
                    6:          base_pick = key_modulus - 31'd1;
                    7:          base_pick = key_modulus;
                    default:    base_pick = 31'($urandom);
                endcase
                send_word(base_pick, ($urandom_range(0, 7) == 0), 1'b0, '0);
            end
        end

        // Let the last results arrive, then watch for strays
        drain_results();
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (mismatch_count == 0)
            $display("** modular_exponentiation: PASSED **");
        else
            $display("** modular_exponentiation: FAILED **");
        $finish;
    end

    // Watchdog
    initial
    begin
        #100_000_000;
        $display("** modular_exponentiation: FAILED **");
        $finish;
    end

endmodule
